// File: design/bme_pkg.sv
// ----------------------------------------------------------------------------
// bme_pkg
// Shared widths, reset values and defaults for the block mean energy design.
// ----------------------------------------------------------------------------
package bme_pkg;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int CSR_W       = 13;
   localparam int BLOCK_NUM_W = 32;
   localparam int MEAN_W      = 39;
   localparam int SQUARE_W    = 31;   // largest square is 2^30
   localparam int RSP_DATA_W  = 72;   // 32 + 39 packed, padded to bytes

   // Default block length after reset
   localparam logic [CSR_W-1:0] LEN_RESET = 13'd320;

   // Parameter defaults
   localparam int DEFAULT_MAX_BLOCK     = 4096;
   localparam int DEFAULT_FRACTION_BITS = 8;

   // Queue between the accumulate and divide sides
   localparam int FIFO_DEPTH = 4;

endpackage

// File: design/block_mean_energy.sv
// ----------------------------------------------------------------------------
// block_mean_energy
// Short-time energy: mean of squared samples over consecutive blocks.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | tvalid / tready    | tdata: sample
//   rsp     | out       | tvalid / tready    | tdata: block_number, energy_mean
//   csr     | in        | csr_wr_en          | csr_wr_data: block_length
//
// One sample is taken per cycle while the block queue has room.
// Each completed block is accumulated and then divided in the shared
// bit-serial divider, which takes the next block only after loading the last
// result, so short blocks throttle the input through the 4-entry queue.
// Reset clears the sum, sample count, block index and queue; the length
// register returns to 320. A stalled rsp side holds its item while the
// divider finishes the next block.
// ----------------------------------------------------------------------------
module block_mean_energy #(
   parameter int MAX_BLOCK     = bme_pkg::DEFAULT_MAX_BLOCK,
   parameter int FRACTION_BITS = bme_pkg::DEFAULT_FRACTION_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // tdata: [15:0] sample
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bme_pkg::SAMPLE_W-1:0]   req_tdata,
   // tdata: [31:0] block_number, [70:32] energy_mean, [71] zero
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bme_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [bme_pkg::CSR_W-1:0]      csr_wr_data
);
   import bme_pkg::*;

   localparam int LEN_W   = $clog2(MAX_BLOCK + 1);
   localparam int SUM_W   = SQUARE_W + $clog2(MAX_BLOCK);
   localparam int ENTRY_W = BLOCK_NUM_W + SUM_W + LEN_W;

   logic [CSR_W-1:0]       length_ff, length_in;
   logic                   fifo_room;
   logic                   fifo_not_empty;
   logic                   push;
   logic                   pop;
   logic [ENTRY_W-1:0]     push_data;
   logic [ENTRY_W-1:0]     pop_data;
   logic [BLOCK_NUM_W-1:0] expect_blk_ff, expect_blk_in;

   // Capture block length writes
   assign length_in = csr_wr_en ? csr_wr_data : length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LEN_RESET;
      end else begin
         length_ff <= length_in;
      end
   end

   bme_front #(
      .MAX_BLOCK     (MAX_BLOCK),
      .FRACTION_BITS (FRACTION_BITS),
      .LEN_W         (LEN_W),
      .SUM_W         (SUM_W),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .block_length (length_ff),
      .fifo_room    (fifo_room),
      .push         (push),
      .push_data    (push_data)
   );

   bme_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (fifo_not_empty),
      .room      (fifo_room)
   );

   bme_back #(
      .MAX_BLOCK     (MAX_BLOCK),
      .FRACTION_BITS (FRACTION_BITS),
      .LEN_W         (LEN_W),
      .SUM_W         (SUM_W),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (fifo_not_empty),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Track the block index the next result item must carry
   assign expect_blk_in = (rsp_tvalid && rsp_tready) ? expect_blk_ff + 1'b1
                                                     : expect_blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_blk_ff <= '0;
      end else begin
         expect_blk_ff <= expect_blk_in;
      end
   end

   // Results come out in block order with no gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[BLOCK_NUM_W-1:0] == expect_blk_ff))
      else $error("result block number out of sequence");

   // Backpressure on samples only while blocks are queued
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> fifo_not_empty)
      else $error("sample input stalled with an empty queue");

   // No result item straight out of reset
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// File: design/bme_front.sv
// ----------------------------------------------------------------------------
// bme_front
// Accepts samples, squares them, accumulates a block sum and pushes one
// entry {block number, sum, length} into the queue when a block completes.
// ----------------------------------------------------------------------------
module bme_front #(
   parameter int MAX_BLOCK     = bme_pkg::DEFAULT_MAX_BLOCK,
   parameter int FRACTION_BITS = bme_pkg::DEFAULT_FRACTION_BITS,
   parameter int LEN_W         = $clog2(MAX_BLOCK + 1),
   parameter int SUM_W         = bme_pkg::SQUARE_W + $clog2(MAX_BLOCK),
   parameter int ENTRY_W       = bme_pkg::BLOCK_NUM_W + SUM_W + LEN_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bme_pkg::SAMPLE_W-1:0] req_tdata,
   input  logic [bme_pkg::CSR_W-1:0]    block_length,
   input  logic                         fifo_room,
   output logic                         push,
   output logic [ENTRY_W-1:0]           push_data
);
   import bme_pkg::*;

   logic                   accept;
   logic [SAMPLE_W-1:0]    mag;
   logic [2*SAMPLE_W-1:0]  square_full;
   logic [LEN_W-1:0]       len_eff;
   logic [LEN_W-1:0]       count_next;
   logic                   last;
   logic [SUM_W-1:0]       sum_next;

   logic [LEN_W-1:0]       count_ff, count_in;
   logic [BLOCK_NUM_W-1:0] block_ff, block_in;
   logic                   sq_valid_ff, sq_valid_in;
   logic                   sq_last_ff, sq_last_in;
   logic [SQUARE_W-1:0]    sq_ff, sq_in;
   logic [LEN_W-1:0]       sq_len_ff, sq_len_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;

   // Take samples while the queue can absorb one more completed block
   assign req_tready = fifo_room;
   assign accept     = req_tvalid & req_tready;

   // Clamp the programmed length into 1..MAX_BLOCK
   always_comb begin
      if (block_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(block_length) > 32'(MAX_BLOCK)) begin
         len_eff = LEN_W'(MAX_BLOCK);
      end else begin
         len_eff = LEN_W'(block_length);
      end
   end

   // Magnitude and square of the sample; 32768 fits as unsigned
   assign mag         = req_tdata[SAMPLE_W-1] ? (~req_tdata + 1'b1) : req_tdata;
   assign square_full = mag * mag;

   assign count_next = count_ff + 1'b1;
   assign last       = (count_next >= len_eff);

   // Stage one: count and square
   always_comb begin
      count_in    = count_ff;
      sq_valid_in = accept;
      sq_in       = sq_ff;
      sq_last_in  = sq_last_ff;
      sq_len_in   = sq_len_ff;
      if (accept) begin
         count_in   = last ? '0 : count_next;
         sq_in      = square_full[SQUARE_W-1:0];
         sq_last_in = last;
         sq_len_in  = len_eff;
      end
   end

   // Stage two: accumulate, hand off a finished block
   assign sum_next  = sum_ff + SUM_W'(sq_ff);
   assign push      = sq_valid_ff & sq_last_ff;
   assign push_data = {block_ff, sum_next, sq_len_ff};

   always_comb begin
      sum_in   = sum_ff;
      block_in = block_ff;
      if (sq_valid_ff) begin
         sum_in = sq_last_ff ? '0 : sum_next;
      end
      if (push) begin
         block_in = block_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         block_ff    <= '0;
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         block_ff    <= block_in;
         sq_valid_ff <= sq_valid_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff     <= sq_in;
      sq_last_ff <= sq_last_in;
      sq_len_ff <= sq_len_in;
   end

endmodule

// File: design/bme_fifo.sv
// ----------------------------------------------------------------------------
// bme_fifo
// Short queue of completed blocks between the accumulate and divide sides.
// Reports room while two slots remain, covering the block still in flight.
// ----------------------------------------------------------------------------
module bme_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bme_pkg::FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty,
   output logic             room
);
   import bme_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign pop_data  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));

   // Advance pointers with wrap at DEPTH
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/bme_back.sv
// ----------------------------------------------------------------------------
// bme_back
// Pops a completed block, divides (sum << FRACTION_BITS) by the length one
// quotient bit per cycle, saturates to 39 bits and holds the result item.
// ----------------------------------------------------------------------------
module bme_back #(
   parameter int MAX_BLOCK     = bme_pkg::DEFAULT_MAX_BLOCK,
   parameter int FRACTION_BITS = bme_pkg::DEFAULT_FRACTION_BITS,
   parameter int LEN_W         = $clog2(MAX_BLOCK + 1),
   parameter int SUM_W         = bme_pkg::SQUARE_W + $clog2(MAX_BLOCK),
   parameter int ENTRY_W       = bme_pkg::BLOCK_NUM_W + SUM_W + LEN_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           not_empty,
   input  logic [ENTRY_W-1:0]             pop_data,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bme_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bme_pkg::*;

   localparam int NUM_W  = SUM_W + FRACTION_BITS;
   localparam int QUO_W  = (NUM_W > MEAN_W) ? NUM_W : MEAN_W;
   localparam int STEP_W = $clog2(QUO_W);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_DONE   = 3'b100
   } back_state_type;

   back_state_type         state_ff, state_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [BLOCK_NUM_W-1:0] blk_ff, blk_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]  out_data_ff, out_data_in;

   logic [BLOCK_NUM_W-1:0] pop_blk;
   logic [SUM_W-1:0]       pop_sum;
   logic [LEN_W-1:0]       pop_len;
   logic [LEN_W:0]         trial;
   logic                   fits;
   logic                   saturate;
   logic [MEAN_W-1:0]      mean;
   logic                   load_out;

   assign {pop_blk, pop_sum, pop_len} = pop_data;

   // One restoring step: shift in the next numerator bit, try a subtract
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, len_ff});

   // Clip the quotient to the field
   assign saturate = (quo_ff > QUO_W'({MEAN_W{1'b1}}));
   assign mean     = saturate ? {MEAN_W{1'b1}} : quo_ff[MEAN_W-1:0];

   assign load_out = (state_ff == ST_DONE) && (!out_valid_ff || rsp_tready);
   assign pop      = (state_ff == ST_IDLE) && not_empty;

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      blk_in   = blk_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (not_empty) begin
               quo_in   = QUO_W'(pop_sum) << FRACTION_BITS;
               rem_in   = '0;
               len_in   = pop_len;
               blk_in   = pop_blk;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = fits ? LEN_W'(trial - {1'b0, len_ff}) : LEN_W'(trial);
            quo_in  = {quo_ff[QUO_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: hold until taken, reload when free
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = RSP_DATA_W'({mean, blk_ff});
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      len_ff      <= len_in;
      blk_ff      <= blk_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks block_mean_energy: samples go in on the req stream and every block
// result on the rsp stream is compared with a local mean-square predictor.
// A short table of hand-picked samples and lengths runs first, then random
// phases with random idling on both streams, long rsp stalls and the
// extreme block lengths.
// ----------------------------------------------------------------------------
module testbench;
   import bme_pkg::*;

   localparam int SETTLE_CYCLES = 80;      // accumulate plus one full divide
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int RANDOM_ITEMS  = 520;
   localparam int FRAC          = DEFAULT_FRACTION_BITS;
   localparam int LEN_CAP       = DEFAULT_MAX_BLOCK;
   localparam logic [MEAN_W-1:0] MEAN_SAT = '1;

   typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [SAMPLE_W-1:0]     value;    // sample, or block length for ROW_CFG
      logic                    typed;    // expected result given in the row
      logic [BLOCK_NUM_W-1:0]  blk;
      logic [MEAN_W-1:0]       mean;
   } stim_row_type;

   typedef struct packed {
      logic [BLOCK_NUM_W-1:0]  blk;
      logic [MEAN_W-1:0]       mean;
   } energy_type;

   localparam int N_ROWS = 26;
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      // one sample at the reset length: block still open
      '{ROW_SAMPLE, 16'h7FFF, 1'b0, 32'd0, 39'd0},
      '{ROW_CFG,    16'd1,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h8000, 1'b0, 32'd0, 39'd0},
      // single-sample blocks: mean is the square itself
      '{ROW_SAMPLE, 16'h8000, 1'b1, 32'd1, 39'h40_0000_0000},
      '{ROW_SAMPLE, 16'h7FFF, 1'b1, 32'd2, 39'h3F_FF00_0100},
      '{ROW_SAMPLE, 16'h0000, 1'b1, 32'd3, 39'd0},
      '{ROW_SAMPLE, 16'h0001, 1'b1, 32'd4, 39'd256},
      '{ROW_SAMPLE, 16'hFFFF, 1'b1, 32'd5, 39'd256},
      // zero length behaves as one
      '{ROW_CFG,    16'd0,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0002, 1'b1, 32'd6, 39'd1024},
      // mean rounded down
      '{ROW_CFG,    16'd3,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0001, 1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0002, 1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0003, 1'b0, 32'd0, 39'd0},
      // shorten mid-block to a length the count already reached
      '{ROW_CFG,    16'd4,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0005, 1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0005, 1'b0, 32'd0, 39'd0},
      '{ROW_CFG,    16'd2,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0005, 1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h8000, 1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h8000, 1'b1, 32'd9, 39'h40_0000_0000},
      // shorten mid-block to a length not yet reached
      '{ROW_CFG,    16'd5,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h4000, 1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'hC000, 1'b0, 32'd0, 39'd0},
      '{ROW_CFG,    16'd3,    1'b0, 32'd0, 39'd0},
      '{ROW_SAMPLE, 16'h0100, 1'b0, 32'd0, 39'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_W-1:0]       csr_wr_data = '0;

   // predictor state
   logic [CSR_W-1:0]       cur_length = LEN_RESET;
   logic [63:0]            sq_acc = '0;
   int unsigned            acc_count = 0;
   logic [BLOCK_NUM_W-1:0] next_block_idx = '0;

   energy_type             pending_energy [$];
   bit                     gaps_on = 1'b1;
   bit                     stalls_on = 1'b1;
   bit                     hold_pending = 1'b0;
   int                     errors = 0;
   int                     samples_sent = 0;
   int                     blocks_checked = 0;
   int                     length_writes = 0;
   int                     cycle_count = 0;

   block_mean_energy dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Add one square to the block; return 1 with the block energy when it closes
   function automatic bit accumulate_square(input logic [SAMPLE_W-1:0] smp,
                                            output energy_type res);
      int               sval;
      longint           sq;
      int unsigned      eff;
      logic [63:0]      mean_wide;
      sval = $signed(smp);
      sq = longint'(sval) * longint'(sval);
      eff = (cur_length == 0) ? 1 : ((cur_length > LEN_CAP) ? LEN_CAP : cur_length);
      sq_acc += 64'(sq);
      acc_count++;
      res = '0;
      if (acc_count < eff)
         return 1'b0;
      mean_wide = (sq_acc << FRAC) / 64'(eff);
      res.blk = next_block_idx;
      res.mean = (mean_wide > 64'(MEAN_SAT)) ? MEAN_SAT : mean_wide[MEAN_W-1:0];
      next_block_idx++;
      sq_acc = '0;
      acc_count = 0;
      return 1'b1;
   endfunction

   // Mix full-scale, small and fully random samples
   function automatic logic [SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 15));
         3: return 16'hFFFF - 16'($urandom_range(0, 15));
         default: return 16'($urandom());
      endcase
   endfunction

   // Offer one sample after a random gap, hold it until taken, log its result
   task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit use_typed,
                              input energy_type typed_res);
      int         gap;
      bit         took;
      energy_type res;
      gap = gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      samples_sent++;
      if (accumulate_square(smp, res) || use_typed)
         pending_energy.push_back(use_typed ? typed_res : res);
   endtask

   // Wait for all results and the divider to go quiet, then set the length
   task automatic write_length(input logic [CSR_W-1:0] len_value);
      req_tvalid <= 1'b0;
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len_value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      cur_length = len_value;
      length_writes++;
   endtask

   task automatic run_phase(input logic [CSR_W-1:0] len_value, input int n,
                            input bit all_min, input bit hold);
      write_length(len_value);
      gaps_on = hold ? 1'b0 : ($urandom_range(0, 3) != 0);
      hold_pending = hold;
      repeat (n) send_sample(all_min ? 16'h8000 : draw_sample(), 1'b0, '0);
   endtask

   // Stimulus
   initial begin : req_side
      energy_type       typed_res;
      logic [CSR_W-1:0] len_value;
      int               len_eff;
      int               n;
      int               pick;
      int               random_items;
      random_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CFG) begin
            write_length(DIRECTED[i].value[CSR_W-1:0]);
         end else begin
            typed_res.blk  = DIRECTED[i].blk;
            typed_res.mean = DIRECTED[i].mean;
            send_sample(DIRECTED[i].value, DIRECTED[i].typed, typed_res);
         end
      end

      // back the rsp side up with short blocks at full input rate
      run_phase(13'd1, 40, 1'b0, 1'b1);
      run_phase(13'd3, 60, 1'b0, 1'b1);

      // largest and clamped lengths leave the block open; length one then
      // closes it, the full-scale run driving the mean into saturation
      run_phase(13'd4096, 30, 1'b0, 1'b0);
      run_phase(13'd1, 1, 1'b0, 1'b0);
      run_phase(13'h1FFF, 30, 1'b1, 1'b0);
      run_phase(13'd1, 1, 1'b0, 1'b0);

      // random lengths, mostly short, each phase may leave a partial block open
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            len_value = '0;
         else if (pick == 1)
            len_value = CSR_W'($urandom_range(41, 320));
         else
            len_value = CSR_W'($urandom_range(1, 40));
         len_eff = (len_value == 0) ? 1 : int'(len_value);
         n = len_eff * $urandom_range(1, 3) + $urandom_range(0, len_eff - 1);
         if (n > RANDOM_ITEMS - random_items)
            n = RANDOM_ITEMS - random_items;
         run_phase(len_value, n, 1'b0, 1'b0);
         random_items += n;
      end

      // drain and let any stray result show up
      req_tvalid <= 1'b0;
      while (pending_energy.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d samples under %0d length writes; %0d block energies checked.",
               samples_sent, length_writes, blocks_checked);
      $display("Lengths 0, 1, 4096 and 8191, saturated means and long rsp stalls included.");
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, one long hold on request, field checks
   initial begin : rsp_side
      energy_type            exp_res;
      logic [RSP_DATA_W-1:0] word;
      bit                    got;
      int                    stall;
      @(negedge reset);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = stalls_on ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            got  = rsp_tvalid;
            word = rsp_tdata;
            @(posedge clock);
         end while (!got);

         if (pending_energy.size() == 0) begin
            $error("unexpected result: block_number %0d energy_mean %0d",
                   word[BLOCK_NUM_W-1:0], word[BLOCK_NUM_W +: MEAN_W]);
            errors++;
         end else begin
            exp_res = pending_energy.pop_front();
            if (word[BLOCK_NUM_W-1:0] !== exp_res.blk) begin
               $error("block_number: expected %0d, got %0d",
                      exp_res.blk, word[BLOCK_NUM_W-1:0]);
               errors++;
            end
            if (word[BLOCK_NUM_W +: MEAN_W] !== exp_res.mean) begin
               $error("energy_mean: expected %0d, got %0d",
                      exp_res.mean, word[BLOCK_NUM_W +: MEAN_W]);
               errors++;
            end
            blocks_checked++;
         end
         // switch between stalling and full-rate stretches now and then
         if ($urandom_range(0, 29) == 0)
            stalls_on = !stalls_on;
      end
   end

   // Timeout
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_energy.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
